>>> rtl/core/rtirq_pkg.sv
// ---------------------------------------------------------------------------
// Raster timing and interrupt core package
// Shared register addresses, request kinds and raster timing constants.
// ---------------------------------------------------------------------------
`default_nettype none

package rtirq_pkg;

  // Default size of the byte register window
  localparam int unsigned RegCountDefault = 47;

  // Request kinds carried on the input tuser field
  localparam logic [1:0] FuncTick  = 2'd0;
  localparam logic [1:0] FuncRead  = 2'd1;
  localparam logic [1:0] FuncWrite = 2'd2;
  localparam logic [1:0] FuncPen   = 2'd3;

  // Video standard codes
  localparam logic [1:0] StdPal     = 2'd0;
  localparam logic [1:0] StdNtscOld = 2'd1;

  // Registers with dedicated behavior
  localparam logic [5:0] RegCtrl   = 6'h11;
  localparam logic [5:0] RegRaster = 6'h12;
  localparam logic [5:0] RegPenX   = 6'h13;
  localparam logic [5:0] RegPenY   = 6'h14;
  localparam logic [5:0] RegIrq    = 6'h19;
  localparam logic [5:0] RegMask   = 6'h1A;
  localparam logic [5:0] RegCollSs = 6'h1E;
  localparam logic [5:0] RegCollSb = 6'h1F;

  // Frame and line geometry
  localparam logic [8:0] LinesPal     = 9'd312;
  localparam logic [8:0] LinesNtscOld = 9'd262;
  localparam logic [8:0] LinesNtsc    = 9'd263;
  localparam logic [6:0] CyclesPal     = 7'd63;
  localparam logic [6:0] CyclesNtscOld = 7'd64;
  localparam logic [6:0] CyclesNtsc    = 7'd65;

  // Display window and bad-line limits
  localparam logic [8:0] LineDenCheck = 9'h030;
  localparam logic [8:0] LineBadFirst = 9'h030;
  localparam logic [8:0] LineBadLast  = 9'h0F7;

  // Cycle positions within a line
  localparam logic [6:0] CycVcLoad    = 7'd13;
  localparam logic [6:0] CycFetchFirst = 7'd14;
  localparam logic [6:0] CycFetchLast  = 7'd53;
  localparam logic [6:0] CycRowEnd     = 7'd57;
  localparam logic [6:0] CycBaFirst    = 7'd12;
  localparam logic [6:0] CycBaLast     = 7'd54;
  localparam logic [6:0] CycStallFirst = 7'd15;

endpackage

`default_nettype wire

>>> rtl/core/raster_timing_irq_register_core.sv
// ---------------------------------------------------------------------------
// Raster timing, interrupt and register core
// Keeps the raster line and cycle counters, the byte register window, the
// raster compare interrupt, the video counters and the bad-line test.
// ---------------------------------------------------------------------------
// The result is registered: it is valid on m_axis in the cycle after the request is accepted.
// Throughput: one request per cycle while m_axis_tready is high; the whole update
// is one pass of logic between the state registers and the result register.
// Reset: rst_ni clears all control state, the counters, the interrupt
// latches and the valid bits of the plain register store at once.
// Unwritten plain registers read as zero; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module raster_timing_irq_register_core
  import rtirq_pkg::*;
#(
  parameter int unsigned REG_COUNT = RegCountDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // Configuration: video standard
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,

  // Request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [5:0] reg_addr, [13:6] write_data, [22:14] pen_x, [31:23] pen_y
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] func
  input  wire logic [1:0]  s_axis_tuser,

  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data, [8] irq_out, [9] bus_request_low, [10] cpu_stall,
  // [19:11] raster_line, [26:20] raster_cycle, [31:27] zero
  output logic [31:0]      m_axis_tdata,
  // line_done
  output logic             m_axis_tlast
);

  localparam int unsigned IdxW = $clog2(REG_COUNT);

  // -------------------------------------------------------------------------
  // Request fields
  // -------------------------------------------------------------------------
  logic [1:0] func;
  logic [5:0] reg_addr;
  logic [7:0] write_data;
  logic [8:0] pen_x;
  logic [8:0] pen_y;

  assign func       = s_axis_tuser;
  assign reg_addr   = s_axis_tdata[5:0];
  assign write_data = s_axis_tdata[13:6];
  assign pen_x      = s_axis_tdata[22:14];
  assign pen_y      = s_axis_tdata[31:23];

  logic             accept;
  logic             addr_ok;
  logic [IdxW-1:0]  mem_idx;

  // Take a new request whenever the result register is empty or draining
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign addr_ok       = {1'b0, reg_addr} < 7'(REG_COUNT);
  assign mem_idx       = reg_addr[IdxW-1:0];

  // -------------------------------------------------------------------------
  // State
  // -------------------------------------------------------------------------
  logic [1:0] std_q;
  logic [8:0] line_q, line_d;
  logic [6:0] cyc_q, cyc_d;
  logic       den_q, den_d;
  logic [9:0] vc_q, vc_d;
  logic [9:0] vcbase_q, vcbase_d;
  logic [2:0] rc_q, rc_d;
  logic [5:0] vmli_q, vmli_d;
  logic       act_q, act_d;
  logic       matched_q, matched_d;
  logic [3:0] src_q, src_d;
  logic [3:0] mask_q, mask_d;
  logic [7:0] ctrl_q, ctrl_d;
  logic [7:0] raster_q, raster_d;
  logic [7:0] penx_q, penx_d;
  logic [7:0] peny_q, peny_d;

  // Plain register store: at most one write or one registered read per request
  logic [7:0]           mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] mem_vld_q;
  logic                 mem_we;

  // Result register
  logic       rd_mem_sel;
  logic [7:0] rd_fixed;
  logic       rd_mem_sel_q;
  logic [7:0] rd_fixed_q;
  logic [7:0] rd_mem_q;
  logic       rd_vld_q;
  logic       irq_q;
  logic       ba_q;
  logic       stall_q;
  logic       done_q;
  logic [8:0] line_out_q;
  logic [6:0] cyc_out_q;

  // -------------------------------------------------------------------------
  // Frame geometry from the selected standard
  // -------------------------------------------------------------------------
  logic [8:0] lines_per_frame;
  logic [6:0] line_len;

  always_comb begin
    unique case (std_q)
      StdPal: begin
        lines_per_frame = LinesPal;
        line_len        = CyclesPal;
      end
      StdNtscOld: begin
        lines_per_frame = LinesNtscOld;
        line_len        = CyclesNtscOld;
      end
      default: begin
        // Codes 2 and 3 time like the newer NTSC frame
        lines_per_frame = LinesNtsc;
        line_len        = CyclesNtsc;
      end
    endcase
  end

  function automatic logic bad_line(input logic den, input logic [8:0] line,
                                    input logic [2:0] yscroll);
    bad_line = den && (line >= LineBadFirst) && (line <= LineBadLast) &&
               (line[2:0] == yscroll);
  endfunction

  // -------------------------------------------------------------------------
  // Next state and result
  // -------------------------------------------------------------------------
  logic       done;
  logic       cmp_en;
  logic       cmp_hit;
  logic       bad_now;
  logic       ba;
  logic       master;
  logic [6:0] cyc_inc;
  logic [8:0] line_inc;

  always_comb begin
    line_d     = line_q;
    cyc_d      = cyc_q;
    den_d      = den_q;
    vc_d       = vc_q;
    vcbase_d   = vcbase_q;
    rc_d       = rc_q;
    vmli_d     = vmli_q;
    act_d      = act_q;
    matched_d  = matched_q;
    src_d      = src_q;
    mask_d     = mask_q;
    ctrl_d     = ctrl_q;
    raster_d   = raster_q;
    penx_d     = penx_q;
    peny_d     = peny_q;
    done       = 1'b0;
    cmp_en     = 1'b0;
    cmp_hit    = 1'b0;
    bad_now    = 1'b0;
    mem_we     = 1'b0;
    rd_mem_sel = 1'b0;
    rd_fixed   = 8'h00;
    cyc_inc    = cyc_q + 7'd1;
    line_inc   = line_q + 9'd1;

    unique case (func)
      FuncTick: begin
        // Latch display enable on the check line before advancing
        if ((line_q == LineDenCheck) && ctrl_q[4]) begin
          den_d = 1'b1;
        end
        if (cyc_inc >= line_len) begin
          cyc_d = 7'd0;
          done  = 1'b1;
          if (line_inc >= lines_per_frame) begin
            line_d = 9'd0;
            den_d  = 1'b0;
          end else begin
            line_d = line_inc;
          end
          if ((line_d == LineDenCheck) && ctrl_q[4]) begin
            den_d = 1'b1;
          end
          cmp_en = 1'b1;
          if (line_d == 9'd0) begin
            vcbase_d = 10'd0;
          end
        end else begin
          cyc_d = cyc_inc;
        end

        // Video counter sequencing on the new cycle position
        bad_now = bad_line(den_d, line_d, ctrl_q[2:0]);
        if (cyc_d == CycVcLoad) begin
          vc_d   = vcbase_d;
          vmli_d = 6'd0;
          if (bad_now) begin
            act_d = 1'b1;
            rc_d  = 3'd0;
          end
        end
        if (act_q && (cyc_d >= CycFetchFirst) && (cyc_d <= CycFetchLast)) begin
          vc_d   = vc_q + 10'd1;
          vmli_d = vmli_q + 6'd1;
        end
        if (cyc_d == CycRowEnd) begin
          if (rc_q == 3'd7) begin
            act_d    = 1'b0;
            vcbase_d = vc_q;
          end
          if (act_d) begin
            rc_d = rc_q + 3'd1;
          end
        end
      end

      FuncRead: begin
        if (!addr_ok) begin
          rd_fixed = 8'hFF;
        end else begin
          unique case (reg_addr) inside
            RegCtrl:   rd_fixed = {line_q[8], ctrl_q[6:0]};
            RegRaster: rd_fixed = line_q[7:0];
            RegPenX:   rd_fixed = penx_q;
            RegPenY:   rd_fixed = peny_q;
            RegIrq:    rd_fixed = {|(src_q & mask_q), 3'b111, src_q};
            RegMask:   rd_fixed = {4'hF, mask_q};
            // Collision latches never set here: read as zero
            RegCollSs, RegCollSb: rd_fixed = 8'h00;
            default:   rd_mem_sel = 1'b1;
          endcase
        end
      end

      FuncWrite: begin
        if (addr_ok) begin
          unique case (reg_addr) inside
            RegCtrl: begin
              ctrl_d = write_data;
              if ((line_q == LineDenCheck) && write_data[4]) begin
                den_d = 1'b1;
              end
              cmp_en = 1'b1;
            end
            RegRaster: begin
              raster_d = write_data;
              cmp_en   = 1'b1;
            end
            // Acknowledge latches written with one
            RegIrq:  src_d  = src_q & ~write_data[3:0];
            RegMask: mask_d = write_data[3:0];
            RegPenX: penx_d = write_data;
            RegPenY: peny_d = write_data;
            // Drop writes to the collision latches
            RegCollSs, RegCollSb: mem_we = 1'b0;
            default: mem_we = 1'b1;
          endcase
        end
      end

      default: begin
        // Light pen strobe: latch position and raise its interrupt
        penx_d   = pen_x[8:1];
        peny_d   = pen_y[7:0];
        src_d[3] = 1'b1;
      end
    endcase

    // Raster compare is edge triggered on the match condition
    if (cmp_en) begin
      cmp_hit = (line_d == {ctrl_d[7], raster_d});
      if (cmp_hit && !matched_q) begin
        src_d[0] = 1'b1;
      end
      matched_d = cmp_hit;
    end

    master = |(src_d & mask_d);
    ba     = bad_line(den_d, line_d, ctrl_d[2:0]) &&
             (cyc_d >= CycBaFirst) && (cyc_d <= CycBaLast);
  end

  // -------------------------------------------------------------------------
  // Control state and counters
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      std_q         <= StdPal;
      line_q        <= 9'd0;
      cyc_q         <= 7'd0;
      den_q         <= 1'b0;
      vc_q          <= 10'd0;
      vcbase_q      <= 10'd0;
      rc_q          <= 3'd0;
      vmli_q        <= 6'd0;
      act_q         <= 1'b0;
      matched_q     <= 1'b0;
      src_q         <= 4'd0;
      mask_q        <= 4'd0;
      ctrl_q        <= 8'd0;
      raster_q      <= 8'd0;
      penx_q        <= 8'd0;
      peny_q        <= 8'd0;
      mem_vld_q     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        std_q <= cfg_wdata_i;
      end
      if (accept) begin
        line_q    <= line_d;
        cyc_q     <= cyc_d;
        den_q     <= den_d;
        vc_q      <= vc_d;
        vcbase_q  <= vcbase_d;
        rc_q      <= rc_d;
        vmli_q    <= vmli_d;
        act_q     <= act_d;
        matched_q <= matched_d;
        src_q     <= src_d;
        mask_q    <= mask_d;
        ctrl_q    <= ctrl_d;
        raster_q  <= raster_d;
        penx_q    <= penx_d;
        peny_q    <= peny_d;
        if (mem_we) begin
          mem_vld_q[mem_idx] <= 1'b1;
        end
      end
      // Hold the result until taken, refill on every accepted request
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Plain register store and result payload
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (mem_we) begin
        mem_q[mem_idx] <= write_data;
      end
      if (rd_mem_sel) begin
        rd_mem_q <= mem_q[mem_idx];
        rd_vld_q <= mem_vld_q[mem_idx];
      end
      rd_mem_sel_q <= rd_mem_sel;
      rd_fixed_q   <= rd_fixed;
      irq_q        <= master;
      ba_q         <= ba;
      stall_q      <= ba && (cyc_d >= CycStallFirst);
      done_q       <= done;
      line_out_q   <= line_d;
      cyc_out_q    <= cyc_d;
    end
  end

  logic [7:0] read_data;

  // Never-written plain registers read as their reset value of zero
  assign read_data = rd_mem_sel_q ? (rd_vld_q ? rd_mem_q : 8'h00) : rd_fixed_q;

  assign m_axis_tdata = {5'd0, cyc_out_q, line_out_q, stall_q, ba_q, irq_q, read_data};
  assign m_axis_tlast = done_q;

endmodule

`default_nettype wire
